>>> rtl/crc8_packet_framer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the CRC-8 packet framer.
// Each macro expands to a concurrent assertion, or to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef CRC8_PACKET_FRAMER_MACROS_SVH
`define CRC8_PACKET_FRAMER_MACROS_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define FRAMER_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("framer assertion failed");
// The expression must never be true.
`define FRAMER_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("framer assertion failed");
`else
`define FRAMER_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define FRAMER_ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

>>> rtl/crc8pf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8pf_pkg
// Types, constants and the CRC-8 fold function shared by the framer modules.
// ----------------------------------------------------------------------------
package crc8pf_pkg;

  // Total frame size: marker, two header bytes, data area, CRC byte.
  localparam int FRAME_BYTES = 67;

  // Size of the data area; also the largest frame length.
  localparam logic [5:0] DATA_CAP = 6'(FRAME_BYTES - 4);
  // Data position of the last padding byte before the CRC byte.
  localparam logic [5:0] PAD_LAST = 6'(FRAME_BYTES - 5);

  localparam logic [7:0] MARKER = 8'h7E;
  localparam logic [7:0] POLY   = 8'h9B;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_FINISH  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] msg_type;
    logic [3:0] sequence_req;
    logic [5:0] length;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR1,
    ST_HDR2,
    ST_PAD,
    ST_CRC
  } state_t;

  // Controller to datapath: at most one is set, and only when the output slot is free.
  typedef struct packed {
    logic start;
    logic payload;
    logic hdr1;
    logic hdr2;
    logic pad;
    logic crc;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic slot_free;
    logic in_frame;
    logic room;
    logic pad_none;
    logic pad_last;
  } status_t;

  // CRC-8, MSB first, no reflection, no final XOR.
  function automatic logic [7:0] crc_fold(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] v;
    v = c ^ b;
    for (int i = 0; i < 8; i++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

>>> rtl/crc8_packet_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_packet_framer
// Builds fixed-size CRC-8 protected frames from start, payload and finish requests.
// ----------------------------------------------------------------------------
// A start request emits the 0x7E marker and then two header bytes. A payload
// request emits its byte, so payload streams at one byte per clock while the
// output side keeps up. A finish request is accepted without a byte of its own;
// the sequencer then steps out the zero fill and padding up to the CRC position
// (data area size minus payload bytes already sent), and then the CRC byte,
// which carries last. The single output register takes one byte per cycle while
// the output side keeps up; the CRC-8 fold of a byte (polynomial 0x9B, MSB
// first, initial value zero) completes within the cycle that loads it. Requests
// are refused while header or trailer bytes are still being stepped out. Payload
// beyond the frame length, payload or finish outside a frame, and the unused kind
// code are accepted and produce nothing.
// ----------------------------------------------------------------------------
`include "crc8_packet_framer_macros.svh"

module crc8_packet_framer (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  crc8pf_pkg::in_t  in_req,
  output logic             out_valid,
  input  logic             out_ready,
  output crc8pf_pkg::out_t out_req
);

  // Commands from the sequencer and status back from the datapath.
  crc8pf_pkg::cmd_t    cmd;
  crc8pf_pkg::status_t status;

  // The sequencer owns the input handshake and decides which byte goes next.
  crc8pf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (in_req.kind),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the frame state, the CRC and the output register.
  crc8pf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_req    (in_req),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_req   (out_req)
  );

  // A byte is only ever loaded into a free output slot.
  `FRAMER_ASSERT_IMPLIES(a_cmd_slot, clk, rst, (|cmd), status.slot_free)
  // Outside a frame there is no payload room left.
  `FRAMER_ASSERT_NEVER(a_room_frame, clk, rst, status.room && !status.in_frame)
  // While the CRC byte waits at the output, the frame has already closed.
  `FRAMER_ASSERT_IMPLIES(a_last_closed, clk, rst, out_valid && out_req.last,
                         !status.in_frame)

endmodule

>>> rtl/crc8pf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8pf_ctrl
// Sequencer for the framer: decodes requests and steps header and trailer bytes.
// ----------------------------------------------------------------------------
module crc8pf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          kind,
  output logic                in_ready,
  input  crc8pf_pkg::status_t status,
  output crc8pf_pkg::cmd_t    cmd
);

  crc8pf_pkg::state_t state;
  crc8pf_pkg::state_t state_next;

  logic take;
  logic is_start;
  logic is_payload;
  logic is_finish;

  assign take       = in_valid && in_ready;
  assign is_start   = kind == crc8pf_pkg::KIND_START;
  assign is_payload = kind == crc8pf_pkg::KIND_PAYLOAD;
  assign is_finish  = kind == crc8pf_pkg::KIND_FINISH;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crc8pf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      crc8pf_pkg::ST_IDLE: begin
        if (take && is_start) begin
          state_next = crc8pf_pkg::ST_HDR1;
        end else if (take && is_finish && status.in_frame) begin
          state_next = status.pad_none ? crc8pf_pkg::ST_CRC : crc8pf_pkg::ST_PAD;
        end
      end
      crc8pf_pkg::ST_HDR1: begin
        if (status.slot_free) state_next = crc8pf_pkg::ST_HDR2;
      end
      crc8pf_pkg::ST_HDR2: begin
        if (status.slot_free) state_next = crc8pf_pkg::ST_IDLE;
      end
      crc8pf_pkg::ST_PAD: begin
        if (status.slot_free && status.pad_last) state_next = crc8pf_pkg::ST_CRC;
      end
      crc8pf_pkg::ST_CRC: begin
        if (status.slot_free) state_next = crc8pf_pkg::ST_IDLE;
      end
      default: state_next = crc8pf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      crc8pf_pkg::ST_IDLE: begin
        in_ready    = status.slot_free;
        cmd.start   = in_valid && status.slot_free && is_start;
        cmd.payload = in_valid && status.slot_free && is_payload && status.in_frame
                      && status.room;
      end
      crc8pf_pkg::ST_HDR1: cmd.hdr1 = status.slot_free;
      crc8pf_pkg::ST_HDR2: cmd.hdr2 = status.slot_free;
      crc8pf_pkg::ST_PAD:  cmd.pad  = status.slot_free;
      crc8pf_pkg::ST_CRC:  cmd.crc  = status.slot_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/crc8pf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8pf_datapath
// Frame state, running CRC and the output register of the framer.
// ----------------------------------------------------------------------------
module crc8pf_datapath (
  input  logic                clk,
  input  logic                rst,
  input  crc8pf_pkg::in_t     in_req,
  input  crc8pf_pkg::cmd_t    cmd,
  output crc8pf_pkg::status_t status,
  output logic                out_valid,
  input  logic                out_ready,
  output crc8pf_pkg::out_t    out_req
);

  logic [7:0] crc_value;
  logic [5:0] bytes_sent;
  logic [5:0] frame_length;
  logic       in_frame;
  logic [5:0] hdr_type;
  logic [3:0] hdr_seq;
  logic [5:0] len_sat;

  assign len_sat = (in_req.length > crc8pf_pkg::DATA_CAP) ? crc8pf_pkg::DATA_CAP
                                                          : in_req.length;

  assign status.slot_free = !out_valid || out_ready;
  assign status.in_frame  = in_frame;
  assign status.room      = bytes_sent < frame_length;
  assign status.pad_none  = bytes_sent >= crc8pf_pkg::DATA_CAP;
  assign status.pad_last  = bytes_sent == crc8pf_pkg::PAD_LAST;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_value    <= '0;
      bytes_sent   <= '0;
      frame_length <= '0;
      in_frame     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      priority if (cmd.start) begin
        frame_length <= len_sat;
        bytes_sent   <= '0;
        crc_value    <= '0;
        in_frame     <= 1'b1;
        out_valid    <= 1'b1;
      end else if (cmd.payload) begin
        crc_value  <= crc8pf_pkg::crc_fold(crc_value, in_req.data_byte);
        bytes_sent <= bytes_sent + 6'd1;
        out_valid  <= 1'b1;
      end else if (cmd.hdr1 || cmd.hdr2) begin
        out_valid <= 1'b1;
      end else if (cmd.pad) begin
        // Zero bytes still owed to the payload enter the CRC; padding does not.
        if (status.room) crc_value <= crc8pf_pkg::crc_fold(crc_value, 8'h00);
        bytes_sent <= bytes_sent + 6'd1;
        out_valid  <= 1'b1;
      end else if (cmd.crc) begin
        crc_value    <= '0;
        bytes_sent   <= '0;
        frame_length <= '0;
        in_frame     <= 1'b0;
        out_valid    <= 1'b1;
      end else begin
        if (out_ready) out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: header fields and the outgoing byte.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hdr_type <= in_req.msg_type;
      hdr_seq  <= in_req.sequence_req;
    end
    priority if (cmd.start) begin
      out_req <= '{out_byte: crc8pf_pkg::MARKER, last: 1'b0};
    end else if (cmd.payload) begin
      out_req <= '{out_byte: in_req.data_byte, last: 1'b0};
    end else if (cmd.hdr1) begin
      out_req <= '{out_byte: {hdr_type, hdr_seq[3:2]}, last: 1'b0};
    end else if (cmd.hdr2) begin
      out_req <= '{out_byte: {hdr_seq[1:0], frame_length}, last: 1'b0};
    end else if (cmd.pad) begin
      out_req <= '{out_byte: 8'h00, last: 1'b0};
    end else if (cmd.crc) begin
      out_req <= '{out_byte: crc_value, last: 1'b1};
    end else begin
      out_req <= out_req;
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for crc8_packet_framer
// A short directed table of start, payload and finish requests, followed by
// random frames with random content. The bench models each request as it
// drives it, keeps the bytes it owes in a queue, and compares every byte that
// leaves the framer against the oldest one owed. Both handshake sides idle at
// random in rotating phases.
// ----------------------------------------------------------------------------
module tb;

  localparam int          HALF_PERIOD   = 10;
  localparam int          RESET_CYCLES  = 12;
  localparam int          RANDOM_ITEMS  = 225;
  localparam int          DRAIN_CYCLES  = 40;
  localparam int          CYCLE_LIMIT   = 1000000;
  localparam int          PHASE_ITEMS   = 45;
  // The kind code the framer leaves unused; it must be swallowed silently.
  localparam logic [1:0]  KIND_UNUSED   = 2'd3;

  // Idling phases, rotated as requests go out.
  localparam int MODE_NONE    = 0;
  localparam int MODE_SENDER  = 1;
  localparam int MODE_STALL   = 2;
  localparam int MODE_BOTH    = 3;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  crc8pf_pkg::in_t  in_req = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  crc8pf_pkg::out_t out_req;

  crc8_packet_framer uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_req   (out_req)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Our own copy of the framer state, advanced once per request.
  logic [7:0] crc_acc = '0;
  logic [5:0] pay_sent = '0;
  logic [5:0] pay_len = '0;
  logic       frame_open = 1'b0;

  // Bytes the framer owes us, oldest first.
  crc8pf_pkg::out_t bytes_owed[$];

  int errors = 0;
  int idle_mode = MODE_NONE;
  int sent_count = 0;
  int cycle_count = 0;

  // One directed request. Where typed is set, the bytes listed here are what
  // the framer must emit; otherwise the frame model supplies them.
  typedef struct {
    logic [1:0] kind;
    logic [5:0] mtype;
    logic [3:0] seq;
    logic [5:0] len;
    logic [7:0] dbyte;
    bit         typed;
    int         ntyped;
    logic [7:0] t0;
    logic [7:0] t1;
    logic [7:0] t2;
  } dir_row_t;

  dir_row_t dir_tab [25];

  // CRC-8 over one byte, poly 0x9B, shifted in one data bit at a time.
  function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] acc;
    logic       fb;
    acc = c;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[7] ^ b[i];
      acc = {acc[6:0], 1'b0} ^ (fb ? crc8pf_pkg::POLY : 8'h00);
    end
    return acc;
  endfunction

  // Advances the frame model by one request and returns how many bytes it
  // causes. When record is set, those bytes are queued as owed.
  function automatic int frame_predict(input crc8pf_pkg::in_t r, input bit record);
    crc8pf_pkg::out_t produced[$];
    logic [5:0]       len;
    case (r.kind)
      crc8pf_pkg::KIND_START: begin
        len = (r.length > crc8pf_pkg::DATA_CAP) ? crc8pf_pkg::DATA_CAP : r.length;
        pay_len    = len;
        pay_sent   = '0;
        crc_acc    = '0;
        frame_open = 1'b1;
        produced.push_back({crc8pf_pkg::MARKER, 1'b0});
        produced.push_back({r.msg_type, r.sequence_req[3:2], 1'b0});
        produced.push_back({r.sequence_req[1:0], len, 1'b0});
      end
      crc8pf_pkg::KIND_PAYLOAD: begin
        if (frame_open && pay_sent < pay_len) begin
          crc_acc = crc8_byte(crc_acc, r.data_byte);
          pay_sent++;
          produced.push_back({r.data_byte, 1'b0});
        end
      end
      crc8pf_pkg::KIND_FINISH: begin
        if (frame_open) begin
          // Missing payload is filled with zeros that enter the CRC.
          while (pay_sent < pay_len) begin
            crc_acc = crc8_byte(crc_acc, 8'h00);
            pay_sent++;
            produced.push_back({8'h00, 1'b0});
          end
          // Plain padding up to the CRC slot, then the CRC itself.
          for (int pos = 3 + int'(pay_sent); pos < crc8pf_pkg::FRAME_BYTES - 1; pos++) begin
            produced.push_back({8'h00, 1'b0});
          end
          produced.push_back({crc_acc, 1'b1});
          crc_acc    = '0;
          pay_sent   = '0;
          pay_len    = '0;
          frame_open = 1'b0;
        end
      end
      default: ;
    endcase
    if (record) begin
      foreach (produced[i]) bytes_owed.push_back(produced[i]);
    end
    return produced.size();
  endfunction

  // A request with every field random, then given the kind asked for.
  function automatic crc8pf_pkg::in_t rand_req(input logic [1:0] k);
    crc8pf_pkg::in_t r;
    r.kind         = k;
    r.msg_type     = 6'($urandom);
    r.sequence_req = 4'($urandom);
    r.length       = 6'($urandom);
    r.data_byte    = 8'($urandom);
    return r;
  endfunction

  // Presents one request and holds it until the framer takes it. The model is
  // run before the request is shown, so its bytes are owed before any of them
  // can come out. Called and left at a falling edge.
  task automatic push_request(input crc8pf_pkg::in_t r, input bit record, output int n_res);
    while (((idle_mode == MODE_SENDER) && ($urandom_range(99) < 88)) ||
           ((idle_mode == MODE_BOTH) && ($urandom_range(99) < 17))) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    n_res = frame_predict(r, record);
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    idle_mode = (sent_count / PHASE_ITEMS) % 4;
    @(negedge clk);
  endtask

  // Random frames. Most are well formed with random content; some are cut
  // short, overfilled, interrupted by the unused kind or abandoned by a new
  // start, and a few stray requests arrive between frames.
  task automatic random_traffic();
    crc8pf_pkg::in_t r;
    int              n;
    int              useful;
    int              npay;
    int              pick;
    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        // Stray request: payload or finish outside a frame, or the unused kind.
        pick = $urandom_range(2);
        if (pick == 0) begin
          r = rand_req(crc8pf_pkg::KIND_PAYLOAD);
        end else if (pick == 1) begin
          r = rand_req(crc8pf_pkg::KIND_FINISH);
        end else begin
          r = rand_req(KIND_UNUSED);
        end
        push_request(r, 1'b1, n);
        if (n > 0) useful++;
      end else begin
        r = rand_req(crc8pf_pkg::KIND_START);
        pick = $urandom_range(99);
        if (pick < 80) begin
          r.length = 6'($urandom_range(0, 12));
        end else if (pick < 95) begin
          r.length = 6'($urandom_range(13, 62));
        end else begin
          r.length = 6'd63;
        end
        push_request(r, 1'b1, n);
        useful++;
        pick = $urandom_range(99);
        if (pick < 70) begin
          npay = r.length;
        end else if (pick < 85) begin
          npay = $urandom_range(0, r.length);
        end else begin
          npay = r.length + $urandom_range(1, 3);
        end
        for (int i = 0; i < npay; i++) begin
          if ($urandom_range(99) < 5) begin
            push_request(rand_req(KIND_UNUSED), 1'b1, n);
          end
          push_request(rand_req(crc8pf_pkg::KIND_PAYLOAD), 1'b1, n);
          if (n > 0) useful++;
        end
        // Now and then the frame is left open and the next start abandons it.
        if ($urandom_range(99) >= 8) begin
          push_request(rand_req(crc8pf_pkg::KIND_FINISH), 1'b1, n);
          useful++;
        end
      end
    end
  endtask

  // The receiver stalls according to the current idling phase.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (idle_mode == MODE_STALL) begin
      out_ready <= ($urandom_range(99) >= 88);
    end else if (idle_mode == MODE_BOTH) begin
      out_ready <= ($urandom_range(99) >= 17);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every byte taken from the framer must match the oldest byte owed.
  always @(posedge clk) begin
    crc8pf_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (bytes_owed.size() == 0) begin
        $display("%0t: unexpected byte: expected none, got byte %h last %b",
                 $time, out_req.out_byte, out_req.last);
        errors++;
      end else begin
        want = bytes_owed.pop_front();
        if (out_req.out_byte !== want.out_byte || out_req.last !== want.last) begin
          $display("%0t: mismatch: expected byte %h last %b, got byte %h last %b",
                   $time, want.out_byte, want.last, out_req.out_byte, out_req.last);
          errors++;
        end
      end
    end
  end

  // Hard stop if the framer hangs or holds back bytes it owes.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("crc8_packet_framer regression: fail");
      $finish;
    end
  end

  initial begin
    crc8pf_pkg::in_t r;
    int              n;
    // Directed requests. The header bytes and the silent cases are typed in;
    // payload echoes and trailers come from the frame model.
    dir_tab = '{
      // Payload, finish and the unused kind straight after reset: all silent.
      '{crc8pf_pkg::KIND_PAYLOAD, 6'h3F, 4'hF, 6'h3F, 8'hFF, 1'b1, 0, 8'h00, 8'h00, 8'h00},
      '{crc8pf_pkg::KIND_FINISH,  6'h3F, 4'hF, 6'h3F, 8'hFF, 1'b1, 0, 8'h00, 8'h00, 8'h00},
      '{KIND_UNUSED,              6'h3F, 4'hF, 6'h3F, 8'hFF, 1'b1, 0, 8'h00, 8'h00, 8'h00},
      // Start with every header field at its top value.
      '{crc8pf_pkg::KIND_START,   6'h3F, 4'hF, 6'h3F, 8'h00, 1'b1, 3, 8'h7E, 8'hFF, 8'hFF},
      '{crc8pf_pkg::KIND_PAYLOAD, 6'h00, 4'h0, 6'h00, 8'hFF, 1'b0, 0, 8'h00, 8'h00, 8'h00},
      '{crc8pf_pkg::KIND_PAYLOAD, 6'h00, 4'h0, 6'h00, 8'h00, 1'b0, 0, 8'h00, 8'h00, 8'h00},
      '{crc8pf_pkg::KIND_PAYLOAD, 6'h00, 4'h0, 6'h00, 8'hA5, 1'b0, 0, 8'h00, 8'h00, 8'h00},
      // A new start abandons the open frame; all header fields at zero.
      '{crc8pf_pkg::KIND_START,   6'h00, 4'h0, 6'h00, 8'hFF, 1'b1, 3, 8'h7E, 8'h00, 8'h00},
      // Zero length: any payload is excess and dropped.
      '{crc8pf_pkg::KIND_PAYLOAD, 6'h00, 4'h0, 6'h00, 8'h55, 1'b1, 0, 8'h00, 8'h00, 8'h00},
      '{crc8pf_pkg::KIND_FINISH,  6'h00, 4'h0, 6'h00, 8'h00, 1'b0, 0, 8'h00, 8'h00, 8'h00},
      '{crc8pf_pkg::KIND_START,   6'h15, 4'h6, 6'h02, 8'h00, 1'b1, 3, 8'h7E, 8'h55, 8'h82},
      '{crc8pf_pkg::KIND_PAYLOAD, 6'h00, 4'h0, 6'h00, 8'h80, 1'b0, 0, 8'h00, 8'h00, 8'h00},
      '{crc8pf_pkg::KIND_PAYLOAD, 6'h00, 4'h0, 6'h00, 8'h01, 1'b0, 0, 8'h00, 8'h00, 8'h00},
      '{crc8pf_pkg::KIND_PAYLOAD, 6'h00, 4'h0, 6'h00, 8'h7F, 1'b1, 0, 8'h00, 8'h00, 8'h00},
      '{crc8pf_pkg::KIND_FINISH,  6'h00, 4'h0, 6'h00, 8'h00, 1'b0, 0, 8'h00, 8'h00, 8'h00},
      // Short frame finished early: the model supplies the zero fill.
      '{crc8pf_pkg::KIND_START,   6'h2A, 4'h9, 6'h05, 8'h00, 1'b1, 3, 8'h7E, 8'hAA, 8'h45},
      '{crc8pf_pkg::KIND_PAYLOAD, 6'h00, 4'h0, 6'h00, 8'h3C, 1'b0, 0, 8'h00, 8'h00, 8'h00},
      '{KIND_UNUSED,              6'h15, 4'hA, 6'h2A, 8'hC3, 1'b1, 0, 8'h00, 8'h00, 8'h00},
      '{crc8pf_pkg::KIND_FINISH,  6'h00, 4'h0, 6'h00, 8'h00, 1'b0, 0, 8'h00, 8'h00, 8'h00},
      // The framer is idle again after a finish, so a second one is silent.
      '{crc8pf_pkg::KIND_FINISH,  6'h00, 4'h0, 6'h00, 8'h00, 1'b1, 0, 8'h00, 8'h00, 8'h00},
      // Largest length, finished at once: the whole data area is zero fill.
      '{crc8pf_pkg::KIND_START,   6'h00, 4'h0, 6'h3F, 8'h00, 1'b1, 3, 8'h7E, 8'h00, 8'h3F},
      '{crc8pf_pkg::KIND_FINISH,  6'h00, 4'h0, 6'h00, 8'h00, 1'b0, 0, 8'h00, 8'h00, 8'h00},
      '{crc8pf_pkg::KIND_START,   6'h01, 4'h3, 6'h01, 8'h00, 1'b1, 3, 8'h7E, 8'h04, 8'hC1},
      '{crc8pf_pkg::KIND_PAYLOAD, 6'h00, 4'h0, 6'h00, 8'hFF, 1'b0, 0, 8'h00, 8'h00, 8'h00},
      '{crc8pf_pkg::KIND_FINISH,  6'h00, 4'h0, 6'h00, 8'h00, 1'b0, 0, 8'h00, 8'h00, 8'h00}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      r.kind         = dir_tab[i].kind;
      r.msg_type     = dir_tab[i].mtype;
      r.sequence_req = dir_tab[i].seq;
      r.length       = dir_tab[i].len;
      r.data_byte    = dir_tab[i].dbyte;
      // Typed bytes go in before the request is shown to the framer.
      if (dir_tab[i].typed) begin
        if (dir_tab[i].ntyped > 0) bytes_owed.push_back({dir_tab[i].t0, 1'b0});
        if (dir_tab[i].ntyped > 1) bytes_owed.push_back({dir_tab[i].t1, 1'b0});
        if (dir_tab[i].ntyped > 2) bytes_owed.push_back({dir_tab[i].t2, 1'b0});
      end
      push_request(r, !dir_tab[i].typed, n);
    end

    random_traffic();
    in_valid <= 1'b0;

    // Let the last trailer drain, then watch a little longer for stray bytes.
    while (bytes_owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("crc8_packet_framer regression: pass");
    end else begin
      $display("crc8_packet_framer regression: fail");
    end
    $finish;
  end

endmodule
